// ----- rtl/tclq_pkg.sv -----
// ----------------------------------------------------------------------------
// tclq_pkg
// Shared types, constants and the palette distance table for the
// two-colour line quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package tclq_pkg;

	localparam int unsigned NUM_PIXELS = 8;
	localparam int unsigned IDX_W      = 4;
	localparam int unsigned NUM_COLORS = 16;
	localparam int unsigned ERR_W      = 18;	// 3 * 255^2 fits
	localparam int unsigned TOT_W      = 21;	// 8 * 3 * 255^2 fits

	localparam logic [TOT_W-1:0] SCORE_LIMIT = TOT_W'(32767);
	localparam logic [IDX_W-1:0] FIRST_LO    = IDX_W'(1);
	localparam logic [IDX_W-1:0] FIRST_HI    = IDX_W'(2);
	localparam logic [IDX_W-1:0] LAST_LO     = IDX_W'(14);
	localparam logic [IDX_W-1:0] LAST_HI     = IDX_W'(15);

	localparam logic [23:0] PALETTE [NUM_COLORS] = '{
		24'h000000, 24'h000000, 24'h21C842, 24'h5EDC78,
		24'h5455ED, 24'h7D76FC, 24'hD4524D, 24'h42EBF5,
		24'hFC5554, 24'hFF7978, 24'hD4C154, 24'hE6CE80,
		24'h21B03B, 24'hC95BBA, 24'hCCCCCC, 24'hFFFFFF
	};

	typedef logic [ERR_W-1:0] dist_table_t [NUM_COLORS*NUM_COLORS];

	// Squared RGB distance between every pair of palette entries
	function automatic dist_table_t build_dist_table();
		dist_table_t t;
		int dr;
		int dg;
		int db;
		for (int p = 0; p < NUM_COLORS; p++) begin
			for (int q = 0; q < NUM_COLORS; q++) begin
				dr = int'(PALETTE[p][23:16]) - int'(PALETTE[q][23:16]);
				dg = int'(PALETTE[p][15:8]) - int'(PALETTE[q][15:8]);
				db = int'(PALETTE[p][7:0]) - int'(PALETTE[q][7:0]);
				t[p*NUM_COLORS+q] = ERR_W'(dr*dr + dg*dg + db*db);
			end
		end
		return t;
	endfunction

	localparam dist_table_t DIST_TABLE = build_dist_table();

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic last_pair;
		logic pipe_busy;
	} status_t;

endpackage

`default_nettype wire

// ----- rtl/tclq_in_if.sv -----
// ----------------------------------------------------------------------------
// tclq_in_if
// Input channel: one line of eight palette-indexed pixels.
// ----------------------------------------------------------------------------
`default_nettype none

interface tclq_in_if;
	logic       valid;
	logic       ready;
	logic [3:0] pixel_0;
	logic [3:0] pixel_1;
	logic [3:0] pixel_2;
	logic [3:0] pixel_3;
	logic [3:0] pixel_4;
	logic [3:0] pixel_5;
	logic [3:0] pixel_6;
	logic [3:0] pixel_7;

	modport source (
		output valid, pixel_0, pixel_1, pixel_2, pixel_3,
		       pixel_4, pixel_5, pixel_6, pixel_7,
		input  ready
	);
	modport sink (
		input  valid, pixel_0, pixel_1, pixel_2, pixel_3,
		       pixel_4, pixel_5, pixel_6, pixel_7,
		output ready
	);
	modport monitor (
		input valid, ready, pixel_0, pixel_1, pixel_2, pixel_3,
		      pixel_4, pixel_5, pixel_6, pixel_7
	);
endinterface

`default_nettype wire

// ----- rtl/tclq_out_if.sv -----
// ----------------------------------------------------------------------------
// tclq_out_if
// Output channel: pattern byte and colour pair byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface tclq_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] pattern_bits;
	logic [7:0] colour_pair;

	modport source (output valid, pattern_bits, colour_pair, input ready);
	modport sink (input valid, pattern_bits, colour_pair, output ready);
	modport monitor (input valid, ready, pattern_bits, colour_pair);
endinterface

`default_nettype wire

// ----- rtl/tclq_ctrl.sv -----
// ----------------------------------------------------------------------------
// tclq_ctrl
// Controller: takes a line, sweeps all pairs of colours 1 to 15, drains the
// scoring pipeline and hands the winner to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tclq_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output tclq_pkg::cmd_t         cmd,
	input  wire tclq_pkg::status_t status
);

	tclq_pkg::state_t state_q;
	tclq_pkg::state_t state_d;
	logic             out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			tclq_pkg::ST_IDLE: begin
				if (in_valid) state_d = tclq_pkg::ST_RUN;
			end
			tclq_pkg::ST_RUN: begin
				if (status.last_pair) state_d = tclq_pkg::ST_DRAIN;
			end
			tclq_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) state_d = tclq_pkg::ST_FINISH;
			end
			tclq_pkg::ST_FINISH: begin
				if (!out_valid_q || out_ready) state_d = tclq_pkg::ST_IDLE;
			end
			default: begin
				state_d = tclq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.start    = 1'b0;
		cmd.issue    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			tclq_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			tclq_pkg::ST_RUN: begin
				cmd.issue = 1'b1;
			end
			tclq_pkg::ST_DRAIN: begin
			end
			tclq_pkg::ST_FINISH: begin
				// load only once the previous result has been taken
				cmd.load_out = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tclq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

// ----- rtl/tclq_datapath.sv -----
// ----------------------------------------------------------------------------
// tclq_datapath
// Pair scoring pipeline: per-pixel nearest-colour lookup, error sum,
// best-pair tracking and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tclq_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire tclq_pkg::cmd_t    cmd,
	output tclq_pkg::status_t      status,
	input  wire logic [3:0]        pixel_0,
	input  wire logic [3:0]        pixel_1,
	input  wire logic [3:0]        pixel_2,
	input  wire logic [3:0]        pixel_3,
	input  wire logic [3:0]        pixel_4,
	input  wire logic [3:0]        pixel_5,
	input  wire logic [3:0]        pixel_6,
	input  wire logic [3:0]        pixel_7,
	output logic [7:0]             pattern_bits,
	output logic [7:0]             colour_pair
);

	localparam int unsigned NP = tclq_pkg::NUM_PIXELS;
	localparam int unsigned IW = tclq_pkg::IDX_W;
	localparam int unsigned EW = tclq_pkg::ERR_W;
	localparam int unsigned TW = tclq_pkg::TOT_W;

	logic [IW-1:0] pix_q [NP];
	logic [IW-1:0] lo_q;
	logic [IW-1:0] hi_q;

	logic [EW-1:0] err_d [NP];
	logic [NP-1:0] pat_d;

	logic [EW-1:0] err_s1 [NP];
	logic [NP-1:0] pat_s1;
	logic [7:0]    pair_s1;
	logic          v_s1;

	logic [TW-1:0] total_d;
	logic [TW-1:0] total_s2;
	logic [NP-1:0] pat_s2;
	logic [7:0]    pair_s2;
	logic          v_s2;

	logic [TW-1:0] best_total_q;
	logic [NP-1:0] best_pat_q;
	logic [7:0]    best_pair_q;
	logic [7:0]    out_pat_q;
	logic [7:0]    out_pair_q;

	// line and pair counters
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pix_q[0] <= pixel_0;
			pix_q[1] <= pixel_1;
			pix_q[2] <= pixel_2;
			pix_q[3] <= pixel_3;
			pix_q[4] <= pixel_4;
			pix_q[5] <= pixel_5;
			pix_q[6] <= pixel_6;
			pix_q[7] <= pixel_7;
			lo_q     <= tclq_pkg::FIRST_LO;
			hi_q     <= tclq_pkg::FIRST_HI;
		end else if (cmd.issue) begin
			if (hi_q == tclq_pkg::LAST_HI) begin
				lo_q <= lo_q + IW'(1);
				hi_q <= lo_q + IW'(2);
			end else begin
				hi_q <= hi_q + IW'(1);
			end
		end
	end

	assign status.last_pair = (lo_q == tclq_pkg::LAST_LO) && (hi_q == tclq_pkg::LAST_HI);
	assign status.pipe_busy = v_s1 || v_s2;

	// pick the nearer colour per pixel; ties go to the background colour
	always_comb begin
		logic [EW-1:0] e_lo;
		logic [EW-1:0] e_hi;
		for (int i = 0; i < NP; i++) begin
			e_lo = tclq_pkg::DIST_TABLE[{pix_q[i], lo_q}];
			e_hi = tclq_pkg::DIST_TABLE[{pix_q[i], hi_q}];
			pat_d[NP-1-i] = e_lo > e_hi;
			err_d[i]      = (e_lo > e_hi) ? e_hi : e_lo;
		end
	end

	always_comb begin
		total_d = '0;
		for (int i = 0; i < NP; i++) begin
			total_d = total_d + TW'(err_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		err_s1   <= err_d;
		pat_s1   <= pat_d;
		pair_s1  <= {hi_q, lo_q};
		total_s2 <= total_d;
		pat_s2   <= pat_s1;
		pair_s2  <= pair_s1;
	end

	// keep the first strictly lower total
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			best_total_q <= tclq_pkg::SCORE_LIMIT;
			best_pat_q   <= '0;
			best_pair_q  <= '0;
		end else if (v_s2 && (total_s2 < best_total_q)) begin
			best_total_q <= total_s2;
			best_pat_q   <= pat_s2;
			best_pair_q  <= pair_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_pat_q  <= best_pat_q;
			out_pair_q <= best_pair_q;
		end
	end

	assign pattern_bits = out_pat_q;
	assign colour_pair  = out_pair_q;

endmodule

`default_nettype wire

// ----- rtl/two_colour_line_quantizer_top.sv -----
// ----------------------------------------------------------------------------
// two_colour_line_quantizer_top
// For each line the scoring datapath tries one colour pair per cycle (all
// eight pixels in parallel); the controller then waits for its two-stage
// pipeline to drain and see it empty, and loads the output register. With
// a ready receiver the next line can be taken in the cycle after the load.
// The winner of a line is loaded only once the previous result has left
// the output register, and no new line is taken before that load, so a
// stalled receiver holds off the input.
// ----------------------------------------------------------------------------
`default_nettype none

module two_colour_line_quantizer_top (
	input  wire logic clk,
	input  wire logic arst_n,
	tclq_in_if.sink   pix_in,
	tclq_out_if.source res_out
);

	tclq_pkg::cmd_t    cmd;
	tclq_pkg::status_t status;

	tclq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix_in.valid),
		.in_ready  (pix_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.cmd       (cmd),
		.status    (status)
	);

	tclq_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.pixel_0      (pix_in.pixel_0),
		.pixel_1      (pix_in.pixel_1),
		.pixel_2      (pix_in.pixel_2),
		.pixel_3      (pix_in.pixel_3),
		.pixel_4      (pix_in.pixel_4),
		.pixel_5      (pix_in.pixel_5),
		.pixel_6      (pix_in.pixel_6),
		.pixel_7      (pix_in.pixel_7),
		.pattern_bits (res_out.pattern_bits),
		.colour_pair  (res_out.colour_pair)
	);

endmodule

`default_nettype wire

// ----- rtl/tclq_checker.sv -----
// ----------------------------------------------------------------------------
// tclq_checker
// Port-level checks on the quantizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tclq_checker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic       in_ready,
	input  wire logic       out_valid,
	input  wire logic       out_ready,
	input  wire logic [7:0] pattern_bits,
	input  wire logic [7:0] colour_pair
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable(pattern_bits) && $stable(colour_pair))
		else $error("result changed while stalled");

	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (colour_pair == 8'd0) ||
			((colour_pair[3:0] != 4'd0) &&
			 (colour_pair[7:4] > colour_pair[3:0])))
		else $error("colour pair out of order");

	a_empty_pattern: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (colour_pair == 8'd0) |-> pattern_bits == 8'd0)
		else $error("pattern set without a colour pair");

	a_one_line: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("line taken while another is in work");

endmodule

bind two_colour_line_quantizer_top tclq_checker u_tclq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (pix_in.valid),
	.in_ready     (pix_in.ready),
	.out_valid    (res_out.valid),
	.out_ready    (res_out.ready),
	.pattern_bits (res_out.pattern_bits),
	.colour_pair  (res_out.colour_pair)
);

`default_nettype wire
